@@ src/oale_pkg.sv @@
// Shared types and constants for the ordered array list engine.
package oale_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_GET    = 3'd2,
        MODE_FIND   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic check;     // latch status, set up the walk pointer
        logic step;      // issue one store read and move the pointer
        logic put;       // write the inserted value
        logic finish;    // update the count and load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_walk;
        logic is_insert;
        logic walk_end;
        logic pend;
        logic hit;
        logic out_busy;
    } stat_t;

endpackage

@@ src/oale_ctrl.sv @@
// Sequencer for the ordered array list engine.
module oale_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  oale_pkg::stat_t st,
    output oale_pkg::cmd_t  cmd
);
    import oale_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_WALK  = 5'b00100,
        S_PUT   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = st.need_walk ? S_WALK : S_DONE;
            end
            S_WALK: begin
                cmd.step = !st.walk_end && !st.hit;
                if (st.hit) begin
                    state_next = S_DONE;
                end else if (st.walk_end && !st.pend) begin
                    state_next = st.is_insert ? S_PUT : S_DONE;
                end
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!st.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/oale_dp.sv @@
// Datapath: element store, count, walk pointer and result register.
module oale_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [oale_pkg::MODE_W-1:0]        in_mode,
    input  logic [oale_pkg::POS_W-1:0]         in_position,
    input  logic signed [oale_pkg::VAL_W-1:0]  in_value,
    input  oale_pkg::cmd_t                     cmd,
    output oale_pkg::stat_t                    st,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [oale_pkg::STAT_W-1:0]        out_status,
    output logic signed [oale_pkg::VAL_W-1:0]  out_data,
    output logic [oale_pkg::POS_W-1:0]         out_found,
    output logic [oale_pkg::CNT_W-1:0]         out_length
);
    import oale_pkg::*;

    logic [VAL_W-1:0] mem [CAPACITY];

    logic [MODE_W-1:0] mode_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [VAL_W-1:0]  value_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              rd_pend_reg;
    logic [VAL_W-1:0]  rdata_reg;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic [POS_W-1:0]  found_reg;

    logic              out_valid_reg;
    logic [STAT_W-1:0] res_status_reg;
    logic [VAL_W-1:0]  res_data_reg;
    logic [POS_W-1:0]  res_found_reg;
    logic [CNT_W-1:0]  res_length_reg;

    logic             is_ins, is_del, is_get, is_find, is_clr;
    logic [CNT_W-1:0] pos_m1;
    logic [CNT_W-1:0] rd_ptr;
    logic             we;
    logic [ADDR_W-1:0] wa;
    logic [VAL_W-1:0] wd;
    logic             hit;
    logic             walk_end;

    assign is_ins  = (mode_reg == MODE_INSERT);
    assign is_del  = (mode_reg == MODE_DELETE);
    assign is_get  = (mode_reg == MODE_GET);
    assign is_find = (mode_reg == MODE_FIND);
    assign is_clr  = (mode_reg == MODE_CLEAR);
    assign pos_m1  = pos_reg - CNT_W'(1);

    // request check against the current count
    always_comb begin
        stat_next = ST_OK;
        unique case (mode_reg)
            MODE_INSERT: begin
                if (count_reg >= CNT_W'(CAPACITY)) begin
                    stat_next = ST_FULL;
                end else if (pos_reg == '0 || pos_reg > count_reg + CNT_W'(1)) begin
                    stat_next = ST_BADPOS;
                end
            end
            MODE_DELETE, MODE_GET: begin
                if (pos_reg == '0 || pos_reg > count_reg) begin
                    stat_next = ST_BADPOS;
                end
            end
            MODE_FIND: begin
                stat_next = ST_NOTFOUND;
            end
            default: begin
                stat_next = ST_OK;
            end
        endcase
    end

    assign st = '{
        need_walk: is_find || ((is_ins || is_del || is_get) && stat_next == ST_OK),
        is_insert: is_ins,
        walk_end:  walk_end,
        pend:      rd_pend_reg,
        hit:       hit,
        out_busy:  out_valid_reg && !out_ready
    };

    // insert walks down from the top, the others walk up
    always_comb begin
        walk_end = 1'b0;
        rd_ptr   = ptr_reg;
        ptr_next = ptr_reg + CNT_W'(1);
        if (is_ins) begin
            walk_end = (ptr_reg == pos_m1);
            rd_ptr   = ptr_reg - CNT_W'(1);
            ptr_next = ptr_reg - CNT_W'(1);
        end else if (is_del) begin
            walk_end = (ptr_reg + CNT_W'(1) >= count_reg);
            rd_ptr   = ptr_reg + CNT_W'(1);
        end else if (is_get) begin
            walk_end = (ptr_reg == pos_reg);
        end else begin
            walk_end = (ptr_reg == count_reg);
        end
    end

    assign hit = rd_pend_reg && is_find && (rdata_reg == value_reg);

    // shift write-back happens in the cycle after its read
    assign we = (rd_pend_reg && (is_ins || is_del)) || cmd.put;
    assign wa = cmd.put ? pos_m1[ADDR_W-1:0] : rd_idx_reg[ADDR_W-1:0];
    assign wd = cmd.put ? value_reg : rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (cmd.step) begin
            rdata_reg <= mem[rd_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg  <= in_mode;
            pos_reg   <= in_position;
            value_reg <= in_value;
        end
        if (cmd.check) begin
            stat_reg  <= stat_next;
            found_reg <= '0;
            if (is_ins) begin
                ptr_reg <= count_reg;
            end else if (is_find) begin
                ptr_reg <= '0;
            end else begin
                ptr_reg <= pos_m1;
            end
        end else if (cmd.step) begin
            ptr_reg <= ptr_next;
        end
        if (cmd.step) begin
            rd_idx_reg <= ptr_reg;
        end
        if (hit) begin
            stat_reg  <= ST_OK;
            found_reg <= rd_idx_reg + CNT_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (is_clr) begin
            count_next = '0;
        end else if (is_ins && stat_reg == ST_OK) begin
            count_next = count_reg + CNT_W'(1);
        end else if (is_del && stat_reg == ST_OK) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.step;
            if (cmd.finish) begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            res_status_reg <= stat_reg;
            res_data_reg   <= (is_get && stat_reg == ST_OK) ? rdata_reg : '0;
            res_found_reg  <= is_find ? found_reg : '0;
            res_length_reg <= count_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = res_status_reg;
    assign out_data   = res_data_reg;
    assign out_found  = res_found_reg;
    assign out_length = res_length_reg;

endmodule

@@ src/ordered_array_list_engine_top.sv @@
// Top level of the ordered array list engine.
//
//  channel | dir | tdata fields (low bit first)                      | tuser
//  s_      | in  | mode[2:0] position[9:3] value[41:10], pad to 48    | -
//  m_      | out | status[1:0] data[33:2] found_position[40:34]
//          |     | length[47:41]                                      | -
//
// One request at a time; the next one can be taken from the cycle the result shows.
// Clear, unused modes and rejected requests go straight to the result without a walk.
// Insert, delete and find walk the store one entry per cycle through its single read
// and single write port.
// aresetn is synchronous, active low, and empties the list; the store is not cleared.
// A new request is taken while a result waits in the output register; the next
// result then stalls until m_tready takes the previous one.
module ordered_array_list_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[2:0], position[9:3], value[41:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], data[33:2], found_position[40:34],
                                   // length[47:41]
);
    import oale_pkg::*;

    cmd_t  cmd;
    stat_t st;

    logic [STAT_W-1:0]        res_status;
    logic signed [VAL_W-1:0]  res_data;
    logic [POS_W-1:0]         res_found;
    logic [CNT_W-1:0]         res_length;

    oale_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    oale_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_mode     (s_tdata[2:0]),
        .in_position (s_tdata[9:3]),
        .in_value    (s_tdata[41:10]),
        .cmd         (cmd),
        .st          (st),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (res_status),
        .out_data    (res_data),
        .out_found   (res_found),
        .out_length  (res_length)
    );

    assign m_tdata = {res_length, res_found, res_data, res_status};

endmodule
